// ===== hw/rtl/svs_pkg.sv =====
// Shared types, widths and defaults for the supply voltage supervisor.
package svs_pkg;

    localparam int VOLT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LDC_W = 13;
    localparam int LRC_W = 7;
    localparam int LSC_W = 10;
    localparam int TC_W = 10;
    localparam int SC_W = 9;

    localparam int DEF_LOW_DETECT_LIMIT = 5000;
    localparam int DEF_LOW_RELEASE_LIMIT = 100;
    localparam int DEF_LOW_SHUTDOWN_LIMIT = 1000;
    localparam int DEF_TICKS_PER_SECOND = 1000;
    localparam int DEF_HIGH_TIMEOUT_SECONDS = 300;

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_LOW_DET   = 3'd1,
        MODE_LOW_SHDN  = 3'd2,
        MODE_HIGH_DET  = 3'd3,
        MODE_HIGH_SHDN = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD       = 3'd0,
        REG_LOW_HYSTERESIS      = 3'd1,
        REG_LOW_SHUTDOWN_LEVEL  = 3'd2,
        REG_LOW_RECOVER_LEVEL   = 3'd3,
        REG_HIGH_THRESHOLD      = 3'd4,
        REG_HIGH_SHUTDOWN_LEVEL = 3'd5,
        REG_HIGH_RECOVER_LEVEL  = 3'd6,
        REG_SSR_MODE            = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [VOLT_W-1:0] low_threshold;
        logic [VOLT_W-1:0] low_hysteresis;
        logic [VOLT_W-1:0] low_shutdown_level;
        logic [VOLT_W-1:0] low_recover_level;
        logic [VOLT_W-1:0] high_threshold;
        logic [VOLT_W-1:0] high_shutdown_level;
        logic [VOLT_W-1:0] high_recover_level;
        logic              ssr_mode;
    } t_cfg;

    typedef struct packed {
        t_mode            mode;
        logic             low_detected;
        logic             low_shutdown;
        logic             high_detected;
        logic             high_shutdown;
        logic [LDC_W-1:0] low_detect_cnt;
        logic [LRC_W-1:0] low_release_cnt;
        logic [LSC_W-1:0] low_shutdown_cnt;
        logic [TC_W-1:0]  tick_cnt;
        logic [SC_W-1:0]  seconds_cnt;
    } t_state;

endpackage

// ===== hw/rtl/svs_step.sv =====
// Next-state logic of the supervisor for one voltage item.
module svs_step #(
    parameter int LOW_DETECT_LIMIT     = svs_pkg::DEF_LOW_DETECT_LIMIT,
    parameter int LOW_RELEASE_LIMIT    = svs_pkg::DEF_LOW_RELEASE_LIMIT,
    parameter int LOW_SHUTDOWN_LIMIT   = svs_pkg::DEF_LOW_SHUTDOWN_LIMIT,
    parameter int TICKS_PER_SECOND     = svs_pkg::DEF_TICKS_PER_SECOND,
    parameter int HIGH_TIMEOUT_SECONDS = svs_pkg::DEF_HIGH_TIMEOUT_SECONDS
) (
    input  svs_pkg::t_state                 i_state,
    input  svs_pkg::t_cfg                   i_cfg,
    input  logic [svs_pkg::VOLT_W-1:0]      i_supply_voltage,
    input  logic                            i_clear,
    output svs_pkg::t_state                 o_state
);
    import svs_pkg::*;

    localparam logic [LDC_W:0] LDC_LIMIT = (LDC_W+1)'(LOW_DETECT_LIMIT);
    localparam logic [LDC_W-1:0] LDC_RELOAD = LDC_W'(LOW_RELEASE_LIMIT);
    localparam logic [LRC_W-1:0] LRC_RELOAD = LRC_W'(LOW_RELEASE_LIMIT);
    localparam logic [LSC_W:0] LSC_LIMIT = (LSC_W+1)'(LOW_SHUTDOWN_LIMIT);
    localparam logic [TC_W:0] TC_LIMIT = (TC_W+1)'(TICKS_PER_SECOND);
    localparam logic [SC_W:0] SC_LIMIT = (SC_W+1)'(HIGH_TIMEOUT_SECONDS);

    always_comb begin
        logic [LDC_W:0] ldc_inc;
        logic [LSC_W:0] lsc_inc;
        logic [TC_W:0]  tc_inc;
        logic [SC_W:0]  sc_inc;
        t_state         s;

        s = i_state;
        ldc_inc = {1'b0, i_state.low_detect_cnt} + (LDC_W+1)'(1);
        lsc_inc = {1'b0, i_state.low_shutdown_cnt} + (LSC_W+1)'(1);
        tc_inc = {1'b0, i_state.tick_cnt} + (TC_W+1)'(1);
        sc_inc = {1'b0, i_state.seconds_cnt} + (SC_W+1)'(1);

        if (i_clear) begin
            s.low_detected = 1'b0;
            s.low_shutdown = 1'b0;
            s.high_detected = 1'b0;
            s.high_shutdown = 1'b0;
            s.mode = MODE_NORMAL;
        end else begin
            case (i_state.mode)
                MODE_LOW_SHDN: begin
                    s.low_shutdown = 1'b1;
                    if (i_supply_voltage > i_cfg.low_recover_level) begin
                        s.mode = MODE_NORMAL;
                    end
                end
                MODE_LOW_DET: begin
                    s.low_detected = 1'b1;
                    // Shutdown debounce first; a mode set by the hysteresis logic below overrides it.
                    if (i_supply_voltage < i_cfg.low_shutdown_level) begin
                        if (i_cfg.ssr_mode || (lsc_inc > LSC_LIMIT)) begin
                            s.low_shutdown_cnt = '0;
                            s.mode = MODE_LOW_SHDN;
                        end else begin
                            s.low_shutdown_cnt = lsc_inc[LSC_W-1:0];
                        end
                    end else begin
                        s.low_shutdown_cnt = '0;
                    end
                    if (i_supply_voltage > i_cfg.low_hysteresis) begin
                        if (i_state.low_release_cnt == '0) begin
                            s.low_detect_cnt = '0;
                            s.mode = MODE_NORMAL;
                        end else begin
                            s.low_release_cnt = i_state.low_release_cnt - LRC_W'(1);
                            if (i_state.low_detect_cnt == '0) begin
                                s.mode = MODE_NORMAL;
                            end else begin
                                s.low_detect_cnt = i_state.low_detect_cnt - LDC_W'(1);
                            end
                        end
                    end else if (ldc_inc > LDC_LIMIT) begin
                        s.low_detect_cnt = LDC_RELOAD;
                        s.mode = MODE_LOW_SHDN;
                    end else begin
                        s.low_detect_cnt = ldc_inc[LDC_W-1:0];
                    end
                end
                MODE_HIGH_DET: begin
                    s.high_detected = 1'b1;
                    if (!i_cfg.ssr_mode &&
                        (i_supply_voltage > i_cfg.high_shutdown_level)) begin
                        s.mode = MODE_HIGH_SHDN;
                    end else if (!i_cfg.ssr_mode &&
                                 (i_supply_voltage > i_cfg.high_threshold)) begin
                        if (tc_inc > TC_LIMIT) begin
                            s.tick_cnt = '0;
                            if (sc_inc >= SC_LIMIT) begin
                                s.seconds_cnt = '0;
                                s.mode = MODE_HIGH_SHDN;
                            end else begin
                                s.seconds_cnt = sc_inc[SC_W-1:0];
                            end
                        end else begin
                            s.tick_cnt = tc_inc[TC_W-1:0];
                        end
                    end else if (i_supply_voltage < i_cfg.high_recover_level) begin
                        s.mode = MODE_NORMAL;
                    end
                end
                MODE_HIGH_SHDN: begin
                    s.high_shutdown = 1'b1;
                    if (i_supply_voltage < i_cfg.high_recover_level) begin
                        s.mode = MODE_NORMAL;
                    end
                end
                default: begin
                    s.low_detected = 1'b0;
                    s.low_shutdown = 1'b0;
                    s.high_detected = 1'b0;
                    s.high_shutdown = 1'b0;
                    s.mode = MODE_NORMAL;
                    if (i_supply_voltage > i_cfg.high_threshold) begin
                        s.tick_cnt = '0;
                        s.seconds_cnt = '0;
                        s.mode = MODE_HIGH_DET;
                    end else if (i_supply_voltage < i_cfg.low_threshold) begin
                        s.low_release_cnt = LRC_RELOAD;
                        s.low_detect_cnt = '0;
                        s.mode = MODE_LOW_DET;
                    end
                end
            endcase
        end
        o_state = s;
    end

endmodule

// ===== hw/rtl/supply_voltage_supervisor.sv =====
// Top level of the supply voltage supervisor: registers, handshakes and state update.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_supply_voltage, i_clear
//   out     | from block| o_out_valid / i_out_stall  | o_mode_out, o_*_out flags
//   cfg     | to block  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// The state update is one pass of compares and counter increments, and the state
// registers double as the result register.
// A new item is taken in every cycle while the output is free or being taken.
// Reset returns the supervisor to normal with cleared counters and flags, and loads
// the register defaults. A stalled result holds, and the input stalls with it.
module supply_voltage_supervisor #(
    parameter int LOW_DETECT_LIMIT     = svs_pkg::DEF_LOW_DETECT_LIMIT,
    parameter int LOW_RELEASE_LIMIT    = svs_pkg::DEF_LOW_RELEASE_LIMIT,
    parameter int LOW_SHUTDOWN_LIMIT   = svs_pkg::DEF_LOW_SHUTDOWN_LIMIT,
    parameter int TICKS_PER_SECOND     = svs_pkg::DEF_TICKS_PER_SECOND,
    parameter int HIGH_TIMEOUT_SECONDS = svs_pkg::DEF_HIGH_TIMEOUT_SECONDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [svs_pkg::VOLT_W-1:0]      i_supply_voltage,
    input  logic                            i_clear,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_mode_out,
    output logic                            o_low_detected_out,
    output logic                            o_low_shutdown_out,
    output logic                            o_high_detected_out,
    output logic                            o_high_shutdown_out,
    input  logic                            i_cfg_we,
    input  logic [svs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [svs_pkg::VOLT_W-1:0]      i_cfg_data
);
    import svs_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept = i_in_valid && !o_in_stall;

    svs_step #(
        .LOW_DETECT_LIMIT     (LOW_DETECT_LIMIT),
        .LOW_RELEASE_LIMIT    (LOW_RELEASE_LIMIT),
        .LOW_SHUTDOWN_LIMIT   (LOW_SHUTDOWN_LIMIT),
        .TICKS_PER_SECOND     (TICKS_PER_SECOND),
        .HIGH_TIMEOUT_SECONDS (HIGH_TIMEOUT_SECONDS)
    ) u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_supply_voltage (i_supply_voltage),
        .i_clear          (i_clear),
        .o_state          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold <= '0;
            r_cfg.low_hysteresis <= '0;
            r_cfg.low_shutdown_level <= '0;
            r_cfg.low_recover_level <= '0;
            r_cfg.high_threshold <= '1;
            r_cfg.high_shutdown_level <= '1;
            r_cfg.high_recover_level <= '0;
            r_cfg.ssr_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_LOW_THRESHOLD:       r_cfg.low_threshold <= i_cfg_data;
                REG_LOW_HYSTERESIS:      r_cfg.low_hysteresis <= i_cfg_data;
                REG_LOW_SHUTDOWN_LEVEL:  r_cfg.low_shutdown_level <= i_cfg_data;
                REG_LOW_RECOVER_LEVEL:   r_cfg.low_recover_level <= i_cfg_data;
                REG_HIGH_THRESHOLD:      r_cfg.high_threshold <= i_cfg_data;
                REG_HIGH_SHUTDOWN_LEVEL: r_cfg.high_shutdown_level <= i_cfg_data;
                REG_HIGH_RECOVER_LEVEL:  r_cfg.high_recover_level <= i_cfg_data;
                REG_SSR_MODE:            r_cfg.ssr_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mode_out = 3'(r_state.mode);
    assign o_low_detected_out = r_state.low_detected;
    assign o_low_shutdown_out = r_state.low_shutdown;
    assign o_high_detected_out = r_state.high_detected;
    assign o_high_shutdown_out = r_state.high_shutdown;

`ifndef SYNTH
    a_clear_to_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_clear) |=> (r_state.mode == MODE_NORMAL) &&
            !r_state.low_detected && !r_state.low_shutdown &&
            !r_state.high_detected && !r_state.high_shutdown)
        else $error("clear did not return the supervisor to normal");

    a_low_high_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state.low_detected || r_state.low_shutdown) &&
          (r_state.high_detected || r_state.high_shutdown)))
        else $error("low and high flags set together");

    a_high_shdn_flag_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.high_shutdown |->
            (r_state.mode == MODE_HIGH_SHDN) || (r_state.mode == MODE_NORMAL))
        else $error("high shutdown flag outside high shutdown or normal");

    a_low_shdn_flag_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.low_shutdown |->
            (r_state.mode == MODE_LOW_SHDN) || (r_state.mode == MODE_NORMAL))
        else $error("low shutdown flag outside low shutdown or normal");
`endif

endmodule
